// ----- rtl/uvsph_pkg.sv -----
// UV-sphere vertex generator: shared types, constants and helper functions.
// No dependencies; the cells, the top level and the testbench import this package.
package uvsph_pkg;

    localparam int MAX_SECTORS_DEF = 256;
    localparam int MAX_STACKS_DEF  = 256;
    localparam int ANGLE_BITS_DEF  = 16;

    localparam int CNT_W    = 9;    // count registers and grid indices
    localparam int RADIUS_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_SECTORS = 2'd1,
        CFG_STACKS  = 2'd2
    } cfg_reg_t;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
    localparam int          DIV_SHIFT  = 34;

    // Horner divisors; a zero sine divisor marks the final multiply by x
    localparam int HORNER_STEPS = 4;
    localparam int SIN_DIV [HORNER_STEPS] = '{42, 20, 6, 0};
    localparam int COS_DIV [HORNER_STEPS] = '{56, 30, 12, 2};

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] ts;
        logic [30:0] tc;
    } lane_t;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] upper;
        logic [16:0] lower;
        logic        qv;
        logic        vv;
        logic [1:0]  quad_se;
        logic [1:0]  quad_st;
        logic        fold_se;
        logic        fold_st;
    } meta_t;

    // floor(p / d) by reciprocal multiply and one correction step
    function automatic logic [29:0] div_const(input logic [29:0] p, input logic [33:0] m,
                                              input logic [5:0] d);
        logic [63:0] prod;
        logic [29:0] q;
        logic [29:0] r;
        prod = {34'd0, p} * {30'd0, m};
        q    = prod[63:34];
        r    = p - 30'(q * {24'd0, d});
        if (r >= {24'd0, d})
            q = q + 30'd1;
        return q;
    endfunction

endpackage

// ----- rtl/uvsph_if.sv -----
// Request channels of the UV-sphere vertex generator: grid points in, vertices out.
// No dependencies.
interface uvsph_grid_if;
    logic       valid;
    logic       ready;
    logic [8:0] stack_index;
    logic [8:0] sector_index;

    modport source (output valid, stack_index, sector_index, input ready);
    modport sink   (input valid, stack_index, sector_index, output ready);
endinterface

interface uvsph_vert_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [16:0]        upper_index;
    logic [16:0]        lower_index;
    logic               quad_valid;
    logic               vertex_valid;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                    upper_index, lower_index, quad_valid, vertex_valid, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                    upper_index, lower_index, quad_valid, vertex_valid, output ready);
endinterface

// ----- rtl/uvsph_div_cell.sv -----
// One restoring-division cell: a quotient bit for each of two lanes per request.
// Depends on uvsph_pkg.
module uvsph_div_cell
    import uvsph_pkg::*;
#(
    parameter int NW = 25
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  logic [1:0][CNT_W+NW-1:0]    acc_in,
    input  logic [CNT_W-1:0]            i_in,
    input  logic [CNT_W-1:0]            j_in,
    input  logic [1:0][CNT_W-1:0]       divisor,
    input  logic                        down_en,
    output logic                        up_en,
    output logic                        valid_out,
    output logic [1:0][CNT_W+NW-1:0]    acc_out,
    output logic [CNT_W-1:0]            i_out,
    output logic [CNT_W-1:0]            j_out
);

    localparam int AW = CNT_W + NW;

    logic                 valid_reg;
    logic [1:0][AW-1:0]   acc_reg;
    logic [1:0][AW-1:0]   acc_next;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;

    assign up_en = !valid_reg || down_en;

    // {rem, numerator} shifts left; quotient bits fill in from the bottom
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            logic [CNT_W:0] t;
            logic           ge;
            t  = {acc_in[k][AW-1:NW], acc_in[k][NW-1]};
            ge = t >= {1'b0, divisor[k]};
            if (ge)
                t = t - {1'b0, divisor[k]};
            acc_next[k] = {t[CNT_W-1:0], acc_in[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (up_en)
        begin
            acc_reg <= acc_next;
            i_reg   <= i_in;
            j_reg   <= j_in;
        end
    end

    assign valid_out = valid_reg;
    assign acc_out   = acc_reg;
    assign i_out     = i_reg;
    assign j_out     = j_reg;

endmodule

// ----- rtl/uvsph_horner_cell.sv -----
// One Horner step of the sine and cosine series for both angles: multiply, then
// constant divide, each in its own register stage. Depends on uvsph_pkg.
module uvsph_horner_cell
    import uvsph_pkg::*;
#(
    parameter int D_SIN = 42,
    parameter int D_COS = 56
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  lane_t [1:0] lane_in,
    input  meta_t       meta_in,
    input  logic        down_en,
    output logic        up_en,
    output logic        valid_out,
    output lane_t [1:0] lane_out,
    output meta_t       meta_out
);

    localparam bit          LAST = (D_SIN == 0);
    localparam logic [33:0] M_S  = 34'((64'd1 << DIV_SHIFT) / (D_SIN == 0 ? 1 : D_SIN));
    localparam logic [33:0] M_C  = 34'((64'd1 << DIV_SHIFT) / D_COS);

    logic        v0_reg, v1_reg;
    logic        en0, en1;
    lane_t [1:0] s0_reg, s0_next;
    lane_t [1:0] s1_reg, s1_next;
    meta_t       m0_reg, m1_reg;

    assign en1   = !v1_reg || down_en;
    assign en0   = !v0_reg || en1;
    assign up_en = en0;

    // last sine step multiplies by x instead of x^2 and skips the divide
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            logic [60:0] ps, pc;
            ps = {31'd0, (LAST ? lane_in[a].x : lane_in[a].x2)} * {30'd0, lane_in[a].ts};
            pc = {31'd0, lane_in[a].x2} * {30'd0, lane_in[a].tc};
            s0_next[a]    = lane_in[a];
            s0_next[a].ts = {1'b0, ps[59:30]};
            s0_next[a].tc = {1'b0, pc[59:30]};
        end
    end

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            s1_next[a] = s0_reg[a];
            if (LAST)
                s1_next[a].ts = s0_reg[a].ts;
            else
                s1_next[a].ts = Q30_ONE
                    - {1'b0, div_const(s0_reg[a].ts[29:0], M_S, 6'(D_SIN))};
            s1_next[a].tc = Q30_ONE - {1'b0, div_const(s0_reg[a].tc[29:0], M_C, 6'(D_COS))};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= valid_in;
            if (en1)
                v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_reg <= s0_next;
            m0_reg <= meta_in;
        end
        if (en1)
        begin
            s1_reg <= s1_next;
            m1_reg <= m0_reg;
        end
    end

    assign valid_out = v1_reg;
    assign lane_out  = s1_reg;
    assign meta_out  = m1_reg;

endmodule

// ----- rtl/uv_sphere_vertex_index_gen_unit.sv -----
// UV-sphere vertex generator, top level. Depends on uvsph_pkg, uvsph_if,
// uvsph_div_cell and uvsph_horner_cell.
//
// Takes one grid point per clock and returns one vertex per clock while the
// output is not stalled. A request passes a chain of 9 + max(16, ANGLE_BITS)
// divider cells (one quotient bit each, giving both angles and both texture
// coordinates), then the angle reduction and squaring registers, four two-stage
// Horner cells, the direction product register and the output register. Every
// stage stalls only when the stage after it is full, so bubbles close up and
// requests keep entering while a vertex waits at the output. Configuration is
// written only while the pipeline is empty; the block itself does not enforce this.
module uv_sphere_vertex_index_gen_unit
    import uvsph_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF,
    parameter int MAX_STACKS  = MAX_STACKS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    uvsph_grid_if.sink           grid,
    uvsph_vert_if.source         vert,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam int QW = (AB > 16) ? AB : 16;
    localparam int NW = CNT_W + QW;
    localparam int AW = CNT_W + NW;
    localparam logic [AB-2:0] QUARTER = (AB-1)'(1) << (AB - 2);
    localparam logic [AB-3:0] EIGHTH  = (AB-2)'(1) << (AB - 3);
    localparam logic [AB-1:0] ST_BASE = AB'(1) << (AB - 2);

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [CNT_W-1:0]    sec_cfg_reg, stk_cfg_reg;
    logic [CNT_W-1:0]    sec, stk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_W'(256);
            sec_cfg_reg <= CNT_W'(36);
            stk_cfg_reg <= CNT_W'(18);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS:  radius_reg  <= cfg_data;
                CFG_SECTORS: sec_cfg_reg <= cfg_data[CNT_W-1:0];
                CFG_STACKS:  stk_cfg_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (sec_cfg_reg == '0)
            sec = CNT_W'(1);
        else if ({4'd0, sec_cfg_reg} > 13'(MAX_SECTORS))
            sec = CNT_W'(MAX_SECTORS);
        else
            sec = sec_cfg_reg;
        if (stk_cfg_reg == '0)
            stk = CNT_W'(1);
        else if ({4'd0, stk_cfg_reg} > 13'(MAX_STACKS))
            stk = CNT_W'(MAX_STACKS);
        else
            stk = stk_cfg_reg;
    end

    // stage enables, back to front
    logic en_out, en_dir, en_sq, en_xr, en_prep;
    logic out_v_reg, dir_v_reg, sq_v_reg, xr_v_reg, prep_v_reg;
    logic div_en [NW+1];
    logic hn_en  [HORNER_STEPS+1];

    assign en_out  = !out_v_reg || vert.ready;
    assign en_dir  = !dir_v_reg || en_out;
    assign hn_en[HORNER_STEPS] = en_dir;
    assign en_sq   = !sq_v_reg || hn_en[0];
    assign en_xr   = !xr_v_reg || en_sq;
    assign en_prep = !prep_v_reg || en_xr;
    assign div_en[NW] = en_prep;
    assign grid.ready = div_en[0];

    // divider chain: lane 0 = sector, lane 1 = stack, numerators shifted by QW
    logic                    div_v   [NW+1];
    logic [1:0][AW-1:0]      div_acc [NW+1];
    logic [CNT_W-1:0]        div_i   [NW+1];
    logic [CNT_W-1:0]        div_j   [NW+1];
    logic [1:0][CNT_W-1:0]   divisor;

    assign divisor    = {stk, sec};
    assign div_v[0]   = grid.valid;
    assign div_acc[0] = {{CNT_W'(0), grid.stack_index, QW'(0)},
                         {CNT_W'(0), grid.sector_index, QW'(0)}};
    assign div_i[0]   = grid.stack_index;
    assign div_j[0]   = grid.sector_index;

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        uvsph_div_cell #(.NW(NW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (div_v[k]),
            .acc_in    (div_acc[k]),
            .i_in      (div_i[k]),
            .j_in      (div_j[k]),
            .divisor   (divisor),
            .down_en   (div_en[k+1]),
            .up_en     (div_en[k]),
            .valid_out (div_v[k+1]),
            .acc_out   (div_acc[k+1]),
            .i_out     (div_i[k+1]),
            .j_out     (div_j[k+1])
        );
    end

    // prep: angles, octant fold, texture coordinates, quad indices
    meta_t             prep_meta_reg, prep_meta_next;
    logic [AB-3:0]     prep_rr_reg [2];
    logic [AB-3:0]     prep_rr_next [2];

    always_comb
    begin
        logic [NW-1:0]   q_se, q_st;
        logic [AB-1:0]   ang [2];
        logic [AB-3:0]   r;
        logic            fold [2];
        logic [19:0]     up;
        logic            vv, qv;
        q_se = div_acc[NW][0][NW-1:0];
        q_st = div_acc[NW][1][NW-1:0];
        ang[0] = AB'(q_se >> (QW - AB));
        ang[1] = ST_BASE - AB'(q_st >> (QW - AB + 1));
        for (int a = 0; a < 2; a++)
        begin
            r       = ang[a][AB-3:0];
            fold[a] = r > EIGHTH;
            prep_rr_next[a] = fold[a] ? (AB-2)'(QUARTER - {1'b0, r}) : r;
        end
        vv = (div_i[NW] <= stk) && (div_j[NW] <= sec);
        qv = (div_i[NW] < stk) && (div_j[NW] < sec);
        up = 20'({11'd0, div_i[NW]} * {10'd0, sec + 10'd1}) + {11'd0, div_j[NW]};
        prep_meta_next.tex_u   = 17'(q_se >> (QW - 16));
        prep_meta_next.tex_v   = 17'(q_st >> (QW - 16));
        prep_meta_next.upper   = qv ? up[16:0] : 17'd0;
        prep_meta_next.lower   = qv ? 17'(up + {10'd0, sec} + 20'd1) : 17'd0;
        prep_meta_next.qv      = qv;
        prep_meta_next.vv      = vv;
        prep_meta_next.quad_se = ang[0][AB-1:AB-2];
        prep_meta_next.quad_st = ang[1][AB-1:AB-2];
        prep_meta_next.fold_se = fold[0];
        prep_meta_next.fold_st = fold[1];
    end

    // radians in Q30, then squares
    meta_t         xr_meta_reg, sq_meta_reg;
    logic [29:0]   xr_x_reg [2];
    lane_t [1:0]   sq_lane_reg;

    always_ff @(posedge clk)
    begin
        if (en_prep)
        begin
            prep_meta_reg <= prep_meta_next;
            prep_rr_reg   <= prep_rr_next;
        end
        if (en_xr)
        begin
            xr_meta_reg <= prep_meta_reg;
            for (int a = 0; a < 2; a++)
                xr_x_reg[a] <= 30'(({35'd0, prep_rr_reg[a]} * {(AB-2)'(0), TWO_PI_Q32})
                                   >> (AB + 2));
        end
        if (en_sq)
        begin
            sq_meta_reg <= xr_meta_reg;
            for (int a = 0; a < 2; a++)
            begin
                logic [59:0] p;
                p = {30'd0, xr_x_reg[a]} * {30'd0, xr_x_reg[a]};
                sq_lane_reg[a] <= '{x: xr_x_reg[a], x2: p[59:30], ts: Q30_ONE, tc: Q30_ONE};
            end
        end
    end

    // Horner cells
    logic        hn_v    [HORNER_STEPS+1];
    lane_t [1:0] hn_lane [HORNER_STEPS+1];
    meta_t       hn_meta [HORNER_STEPS+1];

    assign hn_v[0]    = sq_v_reg;
    assign hn_lane[0] = sq_lane_reg;
    assign hn_meta[0] = sq_meta_reg;

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        uvsph_horner_cell #(.D_SIN(SIN_DIV[k]), .D_COS(COS_DIV[k])) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (hn_v[k]),
            .lane_in   (hn_lane[k]),
            .meta_in   (hn_meta[k]),
            .down_en   (hn_en[k+1]),
            .up_en     (hn_en[k]),
            .valid_out (hn_v[k+1]),
            .lane_out  (hn_lane[k+1]),
            .meta_out  (hn_meta[k+1])
        );
    end

    // direction: quadrant signs, then cos(stack) times sin/cos(sector)
    meta_t        dir_meta_reg;
    logic [30:0]  dmag_reg [3];
    logic [30:0]  dmag_next [3];
    logic         dneg_reg [3];
    logic         dneg_next [3];

    always_comb
    begin
        logic [30:0] s, c;
        logic [30:0] sm [2];
        logic [30:0] cm [2];
        logic        sn [2];
        logic        cn [2];
        logic        fold;
        logic [1:0]  quad;
        logic [61:0] px, py;
        meta_t       m;
        m = hn_meta[HORNER_STEPS];
        for (int a = 0; a < 2; a++)
        begin
            fold = (a == 0) ? m.fold_se : m.fold_st;
            quad = (a == 0) ? m.quad_se : m.quad_st;
            s = fold ? hn_lane[HORNER_STEPS][a].tc : hn_lane[HORNER_STEPS][a].ts;
            c = fold ? hn_lane[HORNER_STEPS][a].ts : hn_lane[HORNER_STEPS][a].tc;
            unique case (quad)
                2'd0: begin sm[a] = s; sn[a] = 1'b0; cm[a] = c; cn[a] = 1'b0; end
                2'd1: begin sm[a] = c; sn[a] = 1'b0; cm[a] = s; cn[a] = 1'b1; end
                2'd2: begin sm[a] = s; sn[a] = 1'b1; cm[a] = c; cn[a] = 1'b1; end
                default: begin sm[a] = c; sn[a] = 1'b1; cm[a] = s; cn[a] = 1'b0; end
            endcase
        end
        px = ({31'd0, cm[1]} * {31'd0, cm[0]}) + (62'd1 << 29);
        py = ({31'd0, cm[1]} * {31'd0, sm[0]}) + (62'd1 << 29);
        dmag_next[0] = px[60:30];
        dneg_next[0] = cn[1] ^ cn[0];
        dmag_next[1] = py[60:30];
        dneg_next[1] = cn[1] ^ sn[0];
        dmag_next[2] = sm[1];
        dneg_next[2] = sn[1];
    end

    // output stage: scale by radius, round the normal, blank points off the grid
    logic [23:0] pos_reg  [3];
    logic [15:0] norm_reg [3];
    logic [23:0] pos_next [3];
    logic [15:0] norm_next [3];
    meta_t       out_meta_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [46:0] pm;
            logic [31:0] nr;
            logic [15:0] nm;
            pm = {16'd0, dmag_reg[k]} * {31'd0, radius_reg} + (47'd1 << 22);
            nr = {1'b0, dmag_reg[k]} + (32'd1 << 14);
            nm = nr[30:15];
            pos_next[k] = dneg_reg[k] ? (24'd0 - pm[46:23]) : pm[46:23];
            if (dneg_reg[k])
                norm_next[k] = 16'd0 - nm;
            else
                norm_next[k] = (nm > 16'd32767) ? 16'd32767 : nm;
            if (!dir_meta_reg.vv)
            begin
                pos_next[k]  = '0;
                norm_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_dir)
        begin
            dir_meta_reg <= hn_meta[HORNER_STEPS];
            dmag_reg     <= dmag_next;
            dneg_reg     <= dneg_next;
        end
        if (en_out)
        begin
            out_meta_reg <= dir_meta_reg;
            pos_reg      <= pos_next;
            norm_reg     <= norm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
            xr_v_reg   <= 1'b0;
            sq_v_reg   <= 1'b0;
            dir_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (en_prep)
                prep_v_reg <= div_v[NW];
            if (en_xr)
                xr_v_reg <= prep_v_reg;
            if (en_sq)
                sq_v_reg <= xr_v_reg;
            if (en_dir)
                dir_v_reg <= hn_v[HORNER_STEPS];
            if (en_out)
                out_v_reg <= dir_v_reg;
        end
    end

    assign vert.valid        = out_v_reg;
    assign vert.pos_x        = pos_reg[0];
    assign vert.pos_y        = pos_reg[1];
    assign vert.pos_z        = pos_reg[2];
    assign vert.norm_x       = norm_reg[0];
    assign vert.norm_y       = norm_reg[1];
    assign vert.norm_z       = norm_reg[2];
    assign vert.tex_u        = out_meta_reg.vv ? out_meta_reg.tex_u : 17'd0;
    assign vert.tex_v        = out_meta_reg.vv ? out_meta_reg.tex_v : 17'd0;
    assign vert.upper_index  = out_meta_reg.upper;
    assign vert.lower_index  = out_meta_reg.lower;
    assign vert.quad_valid   = out_meta_reg.qv;
    assign vert.vertex_valid = out_meta_reg.vv;

    // a blocked input means every stage is full and the output is stalled
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !grid.ready |-> (vert.valid && !vert.ready))
        else $error("input blocked with room in the pipeline");

    a_quad_inside_grid: assert property (@(posedge clk) disable iff (!rst_n)
        vert.valid && vert.quad_valid |-> vert.vertex_valid)
        else $error("quad flagged outside the vertex grid");

    a_off_grid_blank: assert property (@(posedge clk) disable iff (!rst_n)
        vert.valid && !vert.vertex_valid |->
            (vert.pos_x == 0 && vert.norm_z == 0 && vert.tex_u == 0 && vert.upper_index == 0))
        else $error("point off the grid carries data");

    a_no_quad_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        vert.valid && !vert.quad_valid |-> (vert.upper_index == 0 && vert.lower_index == 0))
        else $error("indices given for a point with no quad");

endmodule

// ----- tb/uv_sphere_vertex_index_gen_unit_tb.sv -----
// Testbench for uv_sphere_vertex_index_gen_unit: grid points in, checked vertices out.
// Depends on uvsph_pkg and uvsph_if from the RTL; predicts every vertex in fixed point
// and compares it field by field while both channels idle and stall at random.
module uv_sphere_vertex_index_gen_unit_tb;
    import uvsph_pkg::*;

    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned TURN_Q32  = 64'd26986075409;
    localparam int              IDLE_LIMIT = 5000;

    typedef struct {
        logic [8:0] stack;
        logic [8:0] sector;
    } grid_pt_t;

    typedef struct {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] upper;
        logic [16:0] lower;
        logic        qv;
        logic        vv;
    } vertex_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    uvsph_grid_if grid_if ();
    uvsph_vert_if vert_if ();

    uv_sphere_vertex_index_gen_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid      (grid_if),
        .vert      (vert_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [15:0] radius_q88;
    logic [8:0]  sectors_raw;
    logic [8:0]  stacks_raw;

    grid_pt_t pending_pts [$];
    vertex_t  expected_verts [$];

    int errors;
    int n_checked;
    int n_quads;
    int n_outside;
    int n_settings;
    int idle_cycles;
    int gap_left;
    int burst_left;
    int stall_mode;
    int stall_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // sin and cos of r up to an eighth turn, Q30, non-negative
    function automatic void octant_sincos(input longint unsigned r,
                                          output longint unsigned s,
                                          output longint unsigned c);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        x  = (r * TURN_Q32) >> 18;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        t  = ONE_Q30 - x2 / 56;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 12;
        c  = ONE_Q30 - ((x2 * t) >> 30) / 2;
    endfunction

    function automatic void turn_sincos(input logic [15:0] a, output longint sn,
                                        output longint cs);
        longint unsigned r;
        longint unsigned s;
        longint unsigned c;
        r = 64'(a[13:0]);
        if (r <= 8192)
            octant_sincos(r, s, c);
        else
            octant_sincos(16384 - r, c, s);
        case (a[15:14])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint mul_round(input longint a, input longint b);
        longint unsigned p;
        p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [23:0] scale_pos(input longint d);
        longint unsigned m;
        m = (longint'(radius_q88) * mag(d) + (64'd1 << 22)) >> 23;
        if (d < 0)
            m = -m;
        return m[23:0];
    endfunction

    function automatic logic [15:0] scale_norm(input longint d);
        longint unsigned m;
        m = (mag(d) + (64'd1 << 14)) >> 15;
        if (d < 0)
        begin
            m = -m;
            return m[15:0];
        end
        return (m > 32767) ? 16'd32767 : m[15:0];
    endfunction

    function automatic longint unsigned eff_count(input logic [8:0] v);
        if (v == 0)
            return 1;
        return (v > 256) ? 256 : 64'(v);
    endfunction

    function automatic vertex_t predict_vertex(input grid_pt_t p);
        vertex_t         v;
        longint unsigned sec;
        longint unsigned stk;
        longint unsigned i;
        longint unsigned j;
        longint unsigned up;
        logic [15:0]     se_ang;
        logic [15:0]     st_ang;
        longint          ss, sc, ts, tc, dx, dy;
        sec = eff_count(sectors_raw);
        stk = eff_count(stacks_raw);
        i   = 64'(p.stack);
        j   = 64'(p.sector);
        v   = '{default: '0};
        v.qv = (i < stk) && (j < sec);
        v.vv = (i <= stk) && (j <= sec);
        if (!v.vv)
            return v;
        se_ang = 16'((j << 16) / sec);
        st_ang = 16'(64'd16384 + 64'd65536 - ((i << 15) / stk));
        turn_sincos(se_ang, ss, sc);
        turn_sincos(st_ang, ts, tc);
        dx = mul_round(tc, sc);
        dy = mul_round(tc, ss);
        v.pos_x  = scale_pos(dx);
        v.pos_y  = scale_pos(dy);
        v.pos_z  = scale_pos(ts);
        v.norm_x = scale_norm(dx);
        v.norm_y = scale_norm(dy);
        v.norm_z = scale_norm(ts);
        v.tex_u  = 17'((j << 16) / sec);
        v.tex_v  = 17'((i << 16) / stk);
        if (v.qv)
        begin
            up      = i * (sec + 1) + j;
            v.upper = up[16:0];
            v.lower = 17'(up + sec + 1);
        end
        return v;
    endfunction

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        $display("mismatch %0d on %s: expected %h, got %h", n_checked, field, want, got);
        errors++;
    endtask

    // sender: bursts and gaps, fed from pending_pts
    always @(posedge clk or negedge rst_n)
    begin
        grid_pt_t p;
        if (!rst_n)
        begin
            grid_if.valid        <= 1'b0;
            grid_if.stack_index  <= '0;
            grid_if.sector_index <= '0;
            gap_left             <= 0;
            burst_left           <= 8;
        end
        else
        begin
            if (grid_if.valid && grid_if.ready)
            begin
                p.stack  = grid_if.stack_index;
                p.sector = grid_if.sector_index;
                expected_verts.insert(expected_verts.size(), predict_vertex(p));
            end
            if (!grid_if.valid || grid_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left      <= gap_left - 1;
                    grid_if.valid <= 1'b0;
                end
                else if (pending_pts.size() > 0)
                begin
                    p = pending_pts.pop_front();
                    grid_if.valid        <= 1'b1;
                    grid_if.stack_index  <= p.stack;
                    grid_if.sector_index <= p.sector;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    grid_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches among three random modes; one mode never stalls
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t e;
        if (!rst_n)
        begin
            vert_if.ready <= 1'b0;
            stall_mode    <= 0;
            stall_count   <= 0;
            idle_cycles   <= 0;
        end
        else
        begin
            if (vert_if.valid && vert_if.ready)
            begin
                if (expected_verts.size() == 0)
                begin
                    $display("vertex with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_verts.pop_front();
                    if (vert_if.pos_x !== e.pos_x)  report("pos_x", e.pos_x, vert_if.pos_x);
                    if (vert_if.pos_y !== e.pos_y)  report("pos_y", e.pos_y, vert_if.pos_y);
                    if (vert_if.pos_z !== e.pos_z)  report("pos_z", e.pos_z, vert_if.pos_z);
                    if (vert_if.norm_x !== e.norm_x) report("norm_x", e.norm_x, vert_if.norm_x);
                    if (vert_if.norm_y !== e.norm_y) report("norm_y", e.norm_y, vert_if.norm_y);
                    if (vert_if.norm_z !== e.norm_z) report("norm_z", e.norm_z, vert_if.norm_z);
                    if (vert_if.tex_u !== e.tex_u)  report("tex_u", e.tex_u, vert_if.tex_u);
                    if (vert_if.tex_v !== e.tex_v)  report("tex_v", e.tex_v, vert_if.tex_v);
                    if (vert_if.upper_index !== e.upper)
                        report("upper_index", e.upper, vert_if.upper_index);
                    if (vert_if.lower_index !== e.lower)
                        report("lower_index", e.lower, vert_if.lower_index);
                    if (vert_if.quad_valid !== e.qv)
                        report("quad_valid", e.qv, vert_if.quad_valid);
                    if (vert_if.vertex_valid !== e.vv)
                        report("vertex_valid", e.vv, vert_if.vertex_valid);
                    n_checked++;
                    if (e.qv)
                        n_quads++;
                    if (!e.vv)
                        n_outside++;
                end
            end
            if (stall_count == 63)
                stall_mode <= $urandom_range(0, 2);
            stall_count <= (stall_count + 1) % 64;
            case (stall_mode)
                0:       vert_if.ready <= 1'b1;
                1:       vert_if.ready <= ($urandom_range(0, 3) != 0);
                default: vert_if.ready <= ($urandom_range(0, 2) == 0);
            endcase
            if ((grid_if.valid && grid_if.ready) || (vert_if.valid && vert_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no progress for %0d cycles", IDLE_LIMIT);
                $display("uv_sphere_vertex_index_gen_unit_tb failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pts.size() != 0 || expected_verts.size() != 0 || grid_if.valid)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_RADIUS:  radius_q88  = value;
            CFG_SECTORS: sectors_raw = value[8:0];
            default:     stacks_raw  = value[8:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(input logic [15:0] rad, input logic [8:0] sec,
                              input logic [8:0] stk);
        wait_drained();
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_SECTORS, {7'd0, sec});
        write_reg(CFG_STACKS, {7'd0, stk});
        n_settings++;
    endtask

    task automatic queue_pt(input int i, input int j);
        grid_pt_t p;
        p.stack  = 9'(i);
        p.sector = 9'(j);
        pending_pts.insert(pending_pts.size(), p);
    endtask

    function automatic logic [8:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(257, 511));
            4:       return 9'($urandom_range(2, 8));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    initial
    begin
        int          stk;
        int          sec;
        logic [15:0] rad;
        radius_q88  = 16'd256;
        sectors_raw = 9'd36;
        stacks_raw  = 9'd18;
        errors = 0; n_checked = 0; n_quads = 0; n_outside = 0; n_settings = 0;
        cfg_we = 1'b0; cfg_index = CFG_RADIUS; cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: poles, equator, grid edges, outside points, all-ones fields
        queue_pt(0, 0);   queue_pt(9, 0);   queue_pt(18, 0);  queue_pt(17, 35);
        queue_pt(18, 36); queue_pt(17, 36); queue_pt(18, 35); queue_pt(19, 0);
        queue_pt(0, 37);  queue_pt(0, 9);   queue_pt(0, 18);  queue_pt(0, 27);
        queue_pt(4, 4);   queue_pt(511, 511); queue_pt(256, 256);
        // radius zero, and all-ones radius
        set_sphere(16'd0, 9'd4, 9'd2);
        queue_pt(1, 1); queue_pt(2, 4); queue_pt(0, 3);
        set_sphere(16'hFFFF, 9'd256, 9'd256);
        queue_pt(128, 32); queue_pt(255, 255); queue_pt(256, 256); queue_pt(257, 0);
        // zero counts act as one, oversized counts as the maximum
        set_sphere(16'h0180, 9'd0, 9'd511);
        queue_pt(0, 0); queue_pt(1, 1); queue_pt(256, 0); queue_pt(300, 0);

        while (n_settings < 13)
        begin
            rad = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF)
                                              : 16'($urandom);
            set_sphere(rad, pick_count(), pick_count());
            stk = int'(eff_count(stacks_raw));
            sec = int'(eff_count(sectors_raw));
            repeat (55)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_pt($urandom_range(0, 511), $urandom_range(0, 511));
                else
                    queue_pt($urandom_range(0, stk + 1 > 511 ? 511 : stk + 1),
                             $urandom_range(0, sec + 1 > 511 ? 511 : sec + 1));
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("checked %0d vertices over %0d sphere settings (%0d with a quad, %0d outside)",
                 n_checked, n_settings, n_quads, n_outside);
        if (errors == 0)
            $display("uv_sphere_vertex_index_gen_unit_tb passed");
        else
            $display("uv_sphere_vertex_index_gen_unit_tb failed");
        $finish;
    end

endmodule

// ----- uv_sphere_vertex_index_gen_unit.f -----
rtl/uvsph_pkg.sv
rtl/uvsph_if.sv
rtl/uvsph_div_cell.sv
rtl/uvsph_horner_cell.sv
rtl/uv_sphere_vertex_index_gen_unit.sv
tb/uv_sphere_vertex_index_gen_unit_tb.sv
